@@ design/cmp_pkg.sv @@
// Shared types and constants of the certificate message parser.
// Used by the channel interfaces, the parse core, the result queue and the top level.
`default_nettype none

package cmp_pkg;

  localparam int MAX_CERTS = 16;
  localparam int BYTE_W    = 8;
  localparam int ST_W      = 3;
  localparam int IDX_W     = 5;
  localparam int POS_W     = 25;
  localparam int LEN_W     = 24;
  localparam int EXT_W     = 16;

  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

  localparam int QDEPTH = 4;
  localparam int PTR_W  = $clog2(QDEPTH);
  localparam int CNT_W  = $clog2(QDEPTH + 1);

  typedef enum logic [ST_W-1:0] {
    ST_OK      = 3'd0,
    ST_TRUNC   = 3'd1,
    ST_BADLEN  = 3'd2,
    ST_TOOMANY = 3'd3,
    ST_EMPTY   = 3'd4
  } status_t;

  typedef enum logic [8:0] {
    PH_CTXLEN  = 9'b0_0000_0001,
    PH_CTX     = 9'b0_0000_0010,
    PH_LISTLEN = 9'b0_0000_0100,
    PH_CLEN    = 9'b0_0000_1000,
    PH_CERT    = 9'b0_0001_0000,
    PH_ELEN    = 9'b0_0010_0000,
    PH_EXT     = 9'b0_0100_0000,
    PH_DRAIN   = 9'b0_1000_0000,
    PH_AFTER   = 9'b1_0000_0000
  } phase_t;

  typedef enum logic {
    KIND_ENTRY = 1'b0,
    KIND_FINAL = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    status_t            status;
    logic [IDX_W-1:0]   entry_index;
    logic [POS_W-1:0]   cert_offset;
    logic [LEN_W-1:0]   cert_length;
    logic               run_end;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

endpackage

`default_nettype wire

@@ design/cmp_msg_if.sv @@
// Input channel of the certificate message parser: one message byte per transaction.
// Depends on cmp_pkg.
`default_nettype none

interface cmp_msg_if;
  import cmp_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink (input valid, input data_byte, input final_byte, output ready);
endinterface

`default_nettype wire

@@ design/cmp_report_if.sv @@
// Result channel of the certificate message parser: one entry report or final status per
// transaction. Depends on cmp_pkg.
`default_nettype none

interface cmp_report_if;
  import cmp_pkg::*;

  logic             valid;
  logic             ready;
  logic             kind;
  logic [ST_W-1:0]  status;
  logic [IDX_W-1:0] entry_index;
  logic [POS_W-1:0] cert_offset;
  logic [LEN_W-1:0] cert_length;
  logic             run_end;

  modport source (output valid, output kind, output status, output entry_index,
                  output cert_offset, output cert_length, output run_end, input ready);
  modport sink (input valid, input kind, input status, input entry_index,
                input cert_offset, input cert_length, input run_end, output ready);
endinterface

`default_nettype wire

@@ design/cmp_parse_core.sv @@
// Parse state and per-byte field logic; emits up to two results for each accepted byte.
// Depends on cmp_pkg.
`default_nettype none

module cmp_parse_core (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       step,
  input  wire logic [cmp_pkg::BYTE_W-1:0] data_byte,
  input  wire logic                       final_byte,
  output cmp_pkg::push_t                  push
);
  import cmp_pkg::*;

  phase_t           phase, phase_next;
  logic [LEN_W-1:0] field_remaining, field_remaining_next;
  logic [LEN_W-1:0] length_accumulator, length_accumulator_next;
  logic [LEN_W-1:0] list_remaining, list_remaining_next;
  logic [POS_W-1:0] byte_position, byte_position_next;
  logic [IDX_W-1:0] entry_count, entry_count_next;
  logic [ST_W-1:0]  latched_error, latched_error_next;
  logic [POS_W-1:0] cert_offset, cert_offset_next;
  logic [LEN_W-1:0] cert_length, cert_length_next;

  logic             go_boundary, go_ext, do_fail, emit;
  status_t          fail_code, final_status;
  logic [POS_W-1:0] pos_inc;
  result_t          entry_res, final_res;

  assign pos_inc = (byte_position < POS_MAX) ? byte_position + POS_W'(1) : POS_MAX;

  always_comb begin
    phase_next              = phase;
    field_remaining_next    = field_remaining;
    length_accumulator_next = length_accumulator;
    list_remaining_next     = list_remaining;
    entry_count_next        = entry_count;
    latched_error_next      = latched_error;
    cert_offset_next        = cert_offset;
    cert_length_next        = cert_length;
    go_boundary             = 1'b0;
    go_ext                  = 1'b0;
    do_fail                 = 1'b0;
    emit                    = 1'b0;
    fail_code               = ST_OK;

    if ((phase == PH_CLEN || phase == PH_CERT || phase == PH_ELEN || phase == PH_EXT ||
         phase == PH_DRAIN) && list_remaining != '0) begin
      list_remaining_next = list_remaining - LEN_W'(1);
    end

    case (phase)
      PH_CTXLEN: begin
        field_remaining_next    = LEN_W'(data_byte);
        length_accumulator_next = '0;
        if (data_byte == '0) begin
          phase_next           = PH_LISTLEN;
          field_remaining_next = LEN_W'(3);
        end else begin
          phase_next = PH_CTX;
        end
      end
      PH_CTX: begin
        if (field_remaining != '0) begin
          field_remaining_next = field_remaining - LEN_W'(1);
        end
        if (field_remaining_next == '0) begin
          phase_next              = PH_LISTLEN;
          field_remaining_next    = LEN_W'(3);
          length_accumulator_next = '0;
        end
      end
      PH_LISTLEN: begin
        length_accumulator_next = {length_accumulator[LEN_W-BYTE_W-1:0], data_byte};
        field_remaining_next    = field_remaining - LEN_W'(1);
        if (field_remaining_next == '0) begin
          list_remaining_next = length_accumulator_next;
          go_boundary         = 1'b1;
        end
      end
      PH_CLEN: begin
        length_accumulator_next = {length_accumulator[LEN_W-BYTE_W-1:0], data_byte};
        field_remaining_next    = field_remaining - LEN_W'(1);
        if (field_remaining_next == '0) begin
          if (length_accumulator_next > list_remaining_next) begin
            do_fail   = 1'b1;
            fail_code = ST_BADLEN;
          end else begin
            cert_offset_next = pos_inc;
            cert_length_next = length_accumulator_next;
            if (length_accumulator_next == '0) begin
              go_ext = 1'b1;
            end else begin
              phase_next           = PH_CERT;
              field_remaining_next = length_accumulator_next;
            end
          end
        end
      end
      PH_CERT: begin
        field_remaining_next = field_remaining - LEN_W'(1);
        if (field_remaining_next == '0) begin
          go_ext = 1'b1;
        end
      end
      PH_ELEN: begin
        length_accumulator_next = {{(LEN_W-EXT_W){1'b0}}, length_accumulator[BYTE_W-1:0],
                                   data_byte};
        field_remaining_next    = field_remaining - LEN_W'(1);
        if (field_remaining_next == '0) begin
          if (length_accumulator_next > list_remaining_next) begin
            do_fail   = 1'b1;
            fail_code = ST_BADLEN;
          end else if (length_accumulator_next != '0) begin
            phase_next           = PH_EXT;
            field_remaining_next = length_accumulator_next;
          end else begin
            emit = 1'b1;
          end
        end
      end
      PH_EXT: begin
        field_remaining_next = field_remaining - LEN_W'(1);
        if (field_remaining_next == '0) begin
          emit = 1'b1;
        end
      end
      PH_DRAIN: begin
        if (list_remaining_next == '0) begin
          phase_next = PH_AFTER;
        end
      end
      default: begin
        phase_next = PH_AFTER;
      end
    endcase

    if (emit) begin
      entry_count_next = entry_count + IDX_W'(1);
      go_boundary      = 1'b1;
    end

    if (go_boundary) begin
      if (list_remaining_next == '0) begin
        phase_next = PH_AFTER;
      end else if (entry_count_next >= IDX_W'(MAX_CERTS)) begin
        do_fail   = 1'b1;
        fail_code = ST_TOOMANY;
      end else if (list_remaining_next < LEN_W'(3)) begin
        do_fail   = 1'b1;
        fail_code = ST_TRUNC;
      end else begin
        phase_next              = PH_CLEN;
        field_remaining_next    = LEN_W'(3);
        length_accumulator_next = '0;
      end
    end

    if (go_ext) begin
      if (list_remaining_next < LEN_W'(2)) begin
        do_fail   = 1'b1;
        fail_code = ST_TRUNC;
      end else begin
        phase_next              = PH_ELEN;
        field_remaining_next    = LEN_W'(2);
        length_accumulator_next = '0;
      end
    end

    if (do_fail) begin
      if (latched_error == ST_OK) begin
        latched_error_next = fail_code;
      end
      phase_next = (list_remaining_next != '0) ? PH_DRAIN : PH_AFTER;
    end

    if (phase_next == PH_LISTLEN) begin
      final_status = ST_TRUNC;
    end else if (phase_next != PH_AFTER) begin
      final_status = ST_BADLEN;
    end else if (latched_error_next != ST_OK) begin
      final_status = status_t'(latched_error_next);
    end else if (entry_count_next == '0) begin
      final_status = ST_EMPTY;
    end else begin
      final_status = ST_OK;
    end
  end

  always_comb begin
    entry_res.kind        = KIND_ENTRY;
    entry_res.status      = ST_OK;
    entry_res.entry_index = entry_count;
    entry_res.cert_offset = cert_offset;
    entry_res.cert_length = cert_length;
    entry_res.run_end     = !final_byte;

    final_res.kind        = KIND_FINAL;
    final_res.status      = final_status;
    final_res.entry_index = entry_count_next;
    final_res.cert_offset = '0;
    final_res.cert_length = '0;
    final_res.run_end     = 1'b1;

    push.first  = emit ? entry_res : final_res;
    push.second = final_res;
    if (!step) begin
      push.count = 2'd0;
    end else begin
      push.count = {1'b0, emit} + {1'b0, final_byte};
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (step && final_byte)) begin
      phase              <= PH_CTXLEN;
      field_remaining    <= '0;
      length_accumulator <= '0;
      list_remaining     <= '0;
      byte_position      <= '0;
      entry_count        <= '0;
      latched_error      <= ST_OK;
      cert_offset        <= '0;
      cert_length        <= '0;
    end else if (step) begin
      phase              <= phase_next;
      field_remaining    <= field_remaining_next;
      length_accumulator <= length_accumulator_next;
      list_remaining     <= list_remaining_next;
      byte_position      <= pos_inc;
      entry_count        <= entry_count_next;
      latched_error      <= latched_error_next;
      cert_offset        <= cert_offset_next;
      cert_length        <= cert_length_next;
    end
  end

  assign byte_position_next = pos_inc;

`ifndef SYNTH
  a_final_restarts: assert property (@(posedge clk) disable iff (rst)
    step && final_byte |=> phase == PH_CTXLEN && entry_count == '0 && byte_position == '0)
    else $error("parser state not restarted after final byte");

  a_error_stops_entries: assert property (@(posedge clk) disable iff (rst)
    latched_error != ST_OK |-> phase == PH_DRAIN || phase == PH_AFTER)
    else $error("entry parsing continues after a latched error");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= IDX_W'(MAX_CERTS))
    else $error("entry count above limit");

  a_position_moves: assert property (@(posedge clk) disable iff (rst)
    step && !final_byte |=> byte_position == $past(byte_position_next))
    else $error("byte position not advanced");
`endif

endmodule

`default_nettype wire

@@ design/cmp_result_queue.sv @@
// Small result queue that takes up to two results per cycle and hands out one.
// Depends on cmp_pkg and cmp_report_if.
`default_nettype none

module cmp_result_queue (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire cmp_pkg::push_t push,
  output logic          room,
  cmp_report_if.source  report
);
  import cmp_pkg::*;

  result_t          mem [QDEPTH];
  logic [PTR_W-1:0] wr_ptr, wr_ptr_next, wr_ptr_inc, rd_ptr, rd_ptr_next;
  logic [CNT_W-1:0] count, count_next;
  logic             pop;
  result_t          head;

  assign wr_ptr_inc  = wr_ptr + PTR_W'(1);
  assign pop         = report.valid && report.ready;
  assign wr_ptr_next = wr_ptr + PTR_W'(push.count);
  assign rd_ptr_next = rd_ptr + PTR_W'(pop);
  assign count_next  = count + CNT_W'(push.count) - CNT_W'(pop);
  assign room        = count <= CNT_W'(QDEPTH - 2);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr_inc] <= push.second;
    end
  end

  assign head               = mem[rd_ptr];
  assign report.valid       = count != '0;
  assign report.kind        = head.kind;
  assign report.status      = head.status;
  assign report.entry_index = head.entry_index;
  assign report.cert_offset = head.cert_offset;
  assign report.cert_length = head.cert_length;
  assign report.run_end     = head.run_end;

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push.count != 2'd0 |-> room)
    else $error("results pushed without room");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QDEPTH))
    else $error("queue count out of range");

  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    push.count == 2'd2 |-> push.first.kind == KIND_ENTRY && !push.first.run_end &&
                           push.second.kind == KIND_FINAL && push.second.run_end)
    else $error("result pair out of order");
`endif

endmodule

`default_nettype wire

@@ design/certificate_message_parser_unit.sv @@
// Certificate message parser, top level: byte channel in, result channel out.
// Depends on cmp_pkg, cmp_msg_if, cmp_report_if, cmp_parse_core, cmp_result_queue.
//
// msg carries one message byte per transaction, final_byte set on the last one.
// report carries one result per transaction: an entry report (kind 0) each time
// an entry closes, and a final status (kind 1) on the last byte with the entry
// count. run_end marks the last result caused by a byte.
// The parse state updates in the cycle a byte is taken; its results are written into the
// result queue and leave on report from there. One byte per cycle is sustained while the
// queue has room; a byte that closes an entry and ends the message yields two results.
// Results sit in a four-entry queue; msg.ready drops while more than two wait,
// so a stalled receiver holds the sender off without losing results.
// After the final byte the parser restarts for a new message.
// Reset empties the queue and returns the parser to the context length byte.
`default_nettype none

module certificate_message_parser_unit (
  input wire logic    clk,
  input wire logic    rst,
  cmp_msg_if.sink     msg,
  cmp_report_if.source report
);
  import cmp_pkg::*;

  push_t push;
  logic  room;
  logic  step;

  assign msg.ready = room;
  assign step      = msg.valid && room;

  cmp_parse_core u_core (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .data_byte  (msg.data_byte),
    .final_byte (msg.final_byte),
    .push       (push)
  );

  cmp_result_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .room   (room),
    .report (report)
  );

endmodule

`default_nettype wire

@@ tb/certificate_message_parser_unit_tb.sv @@
// Testbench for certificate_message_parser_unit: feeds certificate messages one byte per
// transaction, predicts entry reports and final status, and checks every result in order.
// Depends on cmp_pkg, cmp_msg_if, cmp_report_if and the parser RTL.
`timescale 1ns / 100ps

module certificate_message_parser_unit_tb;
  import cmp_pkg::*;

  class cert_msg_tracker;
    phase_t           phase;
    logic [LEN_W-1:0] field_left;
    logic [LEN_W-1:0] len_acc;
    logic [LEN_W-1:0] list_left;
    logic [POS_W-1:0] byte_pos;
    logic [IDX_W-1:0] n_entries;
    status_t          first_error;
    logic [POS_W-1:0] cur_offset;
    logic [LEN_W-1:0] cur_length;
    result_t          step_out[$];
    result_t          expected[$];
    int               fail_count;

    function new();
      fail_count = 0;
      restart();
    endfunction

    function void restart();
      phase       = PH_CTXLEN;
      field_left  = '0;
      len_acc     = '0;
      list_left   = '0;
      byte_pos    = '0;
      n_entries   = '0;
      first_error = ST_OK;
      cur_offset  = '0;
      cur_length  = '0;
    endfunction

    function result_t make_result(kind_t k, status_t st, logic [IDX_W-1:0] idx,
                                  logic [POS_W-1:0] ofs, logic [LEN_W-1:0] len);
      result_t r;
      r.kind        = k;
      r.status      = st;
      r.entry_index = idx;
      r.cert_offset = ofs;
      r.cert_length = len;
      r.run_end     = 1'b0;
      return r;
    endfunction

    function void fail_list(status_t code);
      if (first_error == ST_OK) first_error = code;
      phase = (list_left != 0) ? PH_DRAIN : PH_AFTER;
    endfunction

    function void next_entry();
      if (list_left == 0) begin
        phase = PH_AFTER;
      end else if (n_entries >= MAX_CERTS) begin
        fail_list(ST_TOOMANY);
      end else if (list_left < 3) begin
        fail_list(ST_TRUNC);
      end else begin
        phase      = PH_CLEN;
        field_left = LEN_W'(3);
        len_acc    = '0;
      end
    endfunction

    function void want_ext_len();
      if (list_left < 2) begin
        fail_list(ST_TRUNC);
      end else begin
        phase      = PH_ELEN;
        field_left = LEN_W'(2);
        len_acc    = '0;
      end
    endfunction

    function void close_entry();
      step_out.push_back(make_result(KIND_ENTRY, ST_OK, n_entries, cur_offset, cur_length));
      n_entries++;
      next_entry();
    endfunction

    function void note_byte(logic [7:0] b, logic last);
      logic [POS_W-1:0] pos;
      status_t          st;
      step_out.delete();
      pos = byte_pos;
      if ((phase == PH_CLEN || phase == PH_CERT || phase == PH_ELEN || phase == PH_EXT ||
           phase == PH_DRAIN) && list_left != 0)
        list_left--;
      case (phase)
        PH_CTXLEN: begin
          field_left = {16'h0000, b};
          len_acc    = '0;
          if (b == 8'h00) begin
            phase      = PH_LISTLEN;
            field_left = LEN_W'(3);
          end else begin
            phase = PH_CTX;
          end
        end
        PH_CTX: begin
          if (field_left != 0) field_left--;
          if (field_left == 0) begin
            phase      = PH_LISTLEN;
            field_left = LEN_W'(3);
            len_acc    = '0;
          end
        end
        PH_LISTLEN: begin
          len_acc = {len_acc[15:0], b};
          field_left--;
          if (field_left == 0) begin
            list_left = len_acc;
            next_entry();
          end
        end
        PH_CLEN: begin
          len_acc = {len_acc[15:0], b};
          field_left--;
          if (field_left == 0) begin
            if (len_acc > list_left) begin
              fail_list(ST_BADLEN);
            end else begin
              cur_offset = (pos < POS_MAX) ? pos + 1'b1 : POS_MAX;
              cur_length = len_acc;
              if (len_acc == 0) begin
                want_ext_len();
              end else begin
                phase      = PH_CERT;
                field_left = len_acc;
              end
            end
          end
        end
        PH_CERT: begin
          field_left--;
          if (field_left == 0) want_ext_len();
        end
        PH_ELEN: begin
          len_acc = {8'h00, len_acc[7:0], b};
          field_left--;
          if (field_left == 0) begin
            if (len_acc > list_left) begin
              fail_list(ST_BADLEN);
            end else if (len_acc != 0) begin
              phase      = PH_EXT;
              field_left = len_acc;
            end else begin
              close_entry();
            end
          end
        end
        PH_EXT: begin
          field_left--;
          if (field_left == 0) close_entry();
        end
        PH_DRAIN: begin
          if (list_left == 0) phase = PH_AFTER;
        end
        default: begin
          phase = PH_AFTER;
        end
      endcase

      if (byte_pos < POS_MAX) byte_pos++;

      if (last) begin
        if (phase == PH_LISTLEN) st = ST_TRUNC;
        else if (phase != PH_AFTER) st = ST_BADLEN;
        else if (first_error != ST_OK) st = first_error;
        else if (n_entries == 0) st = ST_EMPTY;
        else st = ST_OK;
        step_out.push_back(make_result(KIND_FINAL, st, n_entries, '0, '0));
        restart();
      end

      if (step_out.size() != 0) step_out[step_out.size() - 1].run_end = 1'b1;
      foreach (step_out[i]) expected.push_back(step_out[i]);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected: kind %0d status %0d index %0d offset %0d length %0d end %0d",
                   got.kind, got.status, got.entry_index, got.cert_offset, got.cert_length,
                   got.run_end);
        return;
      end
      want = expected.pop_front();
      if (got.kind !== want.kind || got.status !== want.status ||
          got.entry_index !== want.entry_index || got.cert_offset !== want.cert_offset ||
          got.cert_length !== want.cert_length || got.run_end !== want.run_end) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("mismatch: expected kind %0d status %0d index %0d offset %0d length %0d",
                   want.kind, want.status, want.entry_index, want.cert_offset,
                   want.cert_length);
          $display("  expected end %0d, got kind %0d status %0d index %0d offset %0d",
                   want.run_end, got.kind, got.status, got.entry_index, got.cert_offset);
          $display("  got length %0d end %0d", got.cert_length, got.run_end);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  cmp_msg_if    msg_if();
  cmp_report_if report_if();

  certificate_message_parser_unit dut (
    .clk    (clk),
    .rst    (rst),
    .msg    (msg_if),
    .report (report_if)
  );

  cert_msg_tracker tracker = new();
  logic [7:0]      msg_q[$];
  bit              send_eager;
  int              items_sent = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int draw_wait(bit eager);
    return eager ? 0 : $urandom_range(0, 9);
  endfunction

  task automatic send_byte(input logic [7:0] value, input logic last);
    int gap;
    gap = draw_wait(send_eager);
    if (gap > 0) begin
      msg_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    msg_if.valid      <= 1'b1;
    msg_if.data_byte  <= value;
    msg_if.final_byte <= last;
    @(posedge clk);
    while (!msg_if.ready) @(posedge clk);
    tracker.note_byte(value, last);
    items_sent++;
  endtask

  task automatic send_message();
    send_eager = ($urandom_range(0, 3) == 0);
    foreach (msg_q[i]) send_byte(msg_q[i], i == msg_q.size() - 1);
  endtask

  task automatic compose_message();
    int         style;
    int         ctx_len;
    int         n_certs;
    int         c_len;
    int         e_len;
    int         list_bytes;
    int         cut;
    int         idx;
    logic [7:0] body[$];
    msg_q.delete();
    body.delete();
    style = $urandom_range(0, 99);
    if (style >= 90) begin
      repeat ($urandom_range(1, 12)) msg_q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    ctx_len = ($urandom_range(0, 19) == 0) ? $urandom_range(4, 255) : $urandom_range(0, 3);
    case ($urandom_range(0, 19))
      0: n_certs = 0;
      1: n_certs = MAX_CERTS;
      2: n_certs = MAX_CERTS + 1;
      default: n_certs = $urandom_range(1, 4);
    endcase
    for (int i = 0; i < n_certs; i++) begin
      if (n_certs > 4) c_len = $urandom_range(0, 2);
      else if ($urandom_range(0, 9) == 0) c_len = $urandom_range(7, 40);
      else c_len = $urandom_range(0, 6);
      e_len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
      body.push_back(8'(c_len >> 16));
      body.push_back(8'(c_len >> 8));
      body.push_back(8'(c_len));
      repeat (c_len) body.push_back(8'($urandom_range(0, 255)));
      body.push_back(8'(e_len >> 8));
      body.push_back(8'(e_len));
      repeat (e_len) body.push_back(8'($urandom_range(0, 255)));
    end
    list_bytes = body.size();
    if (style >= 60 && style < 75) list_bytes = list_bytes + $urandom_range(0, 6) - 3;
    msg_q.push_back(8'(ctx_len));
    repeat (ctx_len) msg_q.push_back(8'($urandom_range(0, 255)));
    msg_q.push_back(8'(list_bytes >> 16));
    msg_q.push_back(8'(list_bytes >> 8));
    msg_q.push_back(8'(list_bytes));
    foreach (body[i]) msg_q.push_back(body[i]);
    if ($urandom_range(0, 4) == 0)
      repeat ($urandom_range(1, 3)) msg_q.push_back(8'($urandom_range(0, 255)));
    if (style >= 75 && style < 85) begin
      idx = $urandom_range(0, msg_q.size() - 1);
      msg_q[idx] = msg_q[idx] ^ 8'($urandom_range(1, 255));
    end else if (style >= 85) begin
      cut = $urandom_range(1, msg_q.size());
      while (msg_q.size() > cut) void'(msg_q.pop_back());
    end
  endtask

  initial begin
    msg_if.valid      <= 1'b0;
    msg_if.data_byte  <= '0;
    msg_if.final_byte <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    msg_q = '{8'h00};
    send_message();
    msg_q = '{8'hFF};
    send_message();
    msg_q = '{8'h00, 8'h00, 8'h00, 8'h00};
    send_message();
    msg_q = '{8'h00, 8'h00, 8'h00, 8'h01, 8'hFF};
    send_message();
    msg_q = '{8'h00, 8'h00, 8'h00, 8'h05, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF};
    send_message();
    msg_q = '{8'h00, 8'h00, 8'h00, 8'h03, 8'h00, 8'h00, 8'h09};
    send_message();

    while (items_sent < 1750) begin
      compose_message();
      send_message();
    end
    msg_if.valid <= 1'b0;

    while (tracker.expected.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (tracker.fail_count == 0 && tracker.expected.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    int      stall;
    int      n_results;
    bit      eager;
    result_t got;
    n_results = 0;
    eager     = 1'b0;
    report_if.ready <= 1'b0;
    @(negedge rst);
    forever begin
      if (n_results % 32 == 0) eager = ($urandom_range(0, 2) == 0);
      if (n_results == 60 || n_results == 200) stall = 300;
      else stall = draw_wait(eager);
      if (stall > 0) begin
        report_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      report_if.ready <= 1'b1;
      @(posedge clk);
      while (!report_if.valid) @(posedge clk);
      got = {report_if.kind, report_if.status, report_if.entry_index, report_if.cert_offset,
             report_if.cert_length, report_if.run_end};
      tracker.check_result(got);
      n_results++;
    end
  end

  initial begin
    #15_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
